// ----- rtl/gdh_pkg.sv -----
// Shared constants, types and the arctangent table for the distance and heading error block.
package gdh_pkg;

    localparam int CORDIC_STAGES_DEF = 32;
    localparam int CW = 51;
    localparam int ZW = 34;
    localparam int SQ_W = 64;

    localparam logic [23:0] RADIUS_RESET = 24'd6371000;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam logic [32:0] DIST_MAX = 33'h1_FFFF_FFFF;

    localparam logic [1:0] FUNC_POS  = 2'd0;
    localparam logic [1:0] FUNC_HDG  = 2'd1;
    localparam logic [1:0] FUNC_GOAL = 2'd2;

    typedef struct packed {
        logic               start;
        logic               vec;
        logic [31:0]        ang;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } cordic_req_t;

    function automatic logic [29:0] atan_entry(input logic [5:0] idx);
        logic [29:0] r;
        case (idx)
            6'd0:  r = 30'd536870912;
            6'd1:  r = 30'd316933406;
            6'd2:  r = 30'd167458907;
            6'd3:  r = 30'd85004756;
            6'd4:  r = 30'd42667331;
            6'd5:  r = 30'd21354465;
            6'd6:  r = 30'd10679838;
            6'd7:  r = 30'd5340245;
            6'd8:  r = 30'd2670163;
            6'd9:  r = 30'd1335087;
            6'd10: r = 30'd667544;
            6'd11: r = 30'd333772;
            6'd12: r = 30'd166886;
            6'd13: r = 30'd83443;
            6'd14: r = 30'd41722;
            6'd15: r = 30'd20861;
            6'd16: r = 30'd10430;
            6'd17: r = 30'd5215;
            6'd18: r = 30'd2608;
            6'd19: r = 30'd1304;
            6'd20: r = 30'd652;
            6'd21: r = 30'd326;
            6'd22: r = 30'd163;
            6'd23: r = 30'd81;
            6'd24: r = 30'd41;
            6'd25: r = 30'd20;
            6'd26: r = 30'd10;
            6'd27: r = 30'd5;
            6'd28: r = 30'd3;
            6'd29: r = 30'd1;
            6'd30: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/gps_distance_heading_error.sv -----
// Top level: great-circle distance and heading error from a stored fix and heading.
// Position and heading words only update the stored fix and heading. A goal word runs
// six CORDIC passes and two square roots; its result is registered at the output, and
// the next word is taken once the result has been loaded there. Input stalls meanwhile,
// longer on output stall.
// Reset clears the stored fix and heading to zero and sets the radius to 6371000 m.
module gps_distance_heading_error #(
    parameter int CORDIC_STAGES = gdh_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [23:0]        cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic signed [31:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic signed [31:0] heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [32:0]        distance,
    output logic signed [31:0] heading_error
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_CSTART   = 15'b000000000000010,
        S_CWAIT    = 15'b000000000000100,
        S_MUL_CC   = 15'b000000000001000,
        S_MUL_A    = 15'b000000000010000,
        S_SUM_A    = 15'b000000000100000,
        S_SQS_GO   = 15'b000000001000000,
        S_SQS_WAIT = 15'b000000010000000,
        S_SQK_GO   = 15'b000000100000000,
        S_SQK_WAIT = 15'b000001000000000,
        S_MUL_T    = 15'b000010000000000,
        S_MUL_LO   = 15'b000100000000000,
        S_MUL_HI   = 15'b001000000000000,
        S_FINAL    = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } state_t;

    typedef enum logic [2:0] {
        OP_COS_LAT1 = 3'd0,
        OP_COS_LAT2 = 3'd1,
        OP_COS_DLAT = 3'd2,
        OP_COS_DLON = 3'd3,
        OP_BEARING  = 3'd4,
        OP_HALF     = 3'd5
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg;

    logic [23:0] radius_reg;
    logic [31:0] cur_lat_reg;
    logic [31:0] cur_lon_reg;
    logic [31:0] cur_hdg_reg;
    logic [31:0] lat2_reg;
    logic [31:0] dlat_reg;
    logic [31:0] dlon_reg;
    logic signed [31:0] c1_reg;
    logic signed [31:0] c2_reg;
    logic [30:0] hdl_reg;
    logic [30:0] hdn_reg;
    logic [31:0] bearing_reg;
    logic [30:0] a_reg;
    logic [31:0] s_reg;
    logic [31:0] k_reg;
    logic [30:0] half_reg;
    logic [23:0] th_reg;
    logic [31:0] mlo_reg;
    logic [32:0] dist_reg;
    logic        out_valid_reg;
    logic [32:0] out_dist_reg;
    logic [31:0] out_herr_reg;
    logic signed [65:0] prod_reg;

    logic                 accept;
    logic                 out_free;
    gdh_pkg::cordic_req_t creq;
    logic                 c_done;
    logic signed [31:0]   c_cos;
    logic [31:0]          c_ang;
    logic                 sq_start;
    logic [60:0]          sq_val;
    logic                 sq_done;
    logic [31:0]          sq_root;
    logic signed [32:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic [32:0]          hav_full;
    logic signed [33:0]   a_sum;
    logic [57:0]          mid;
    logic [36:0]          d_full;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        creq.start = (state_reg == S_CSTART);
        creq.vec   = (op_reg == OP_BEARING) || (op_reg == OP_HALF);
        case (op_reg)
            OP_COS_LAT1: creq.ang = cur_lat_reg;
            OP_COS_LAT2: creq.ang = lat2_reg;
            OP_COS_DLAT: creq.ang = dlat_reg;
            default:     creq.ang = dlon_reg;
        endcase
        creq.x = (op_reg == OP_BEARING) ? dlat_reg : k_reg;
        creq.y = (op_reg == OP_BEARING) ? dlon_reg : s_reg;
    end

    gdh_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (creq),
        .done    (c_done),
        .cos_val (c_cos),
        .angle   (c_ang)
    );

    assign sq_start = (state_reg == S_SQS_GO) || (state_reg == S_SQK_GO);
    assign sq_val   = (state_reg == S_SQS_GO) ? {a_reg, 30'b0}
                                              : {gdh_pkg::ONE_Q30 - a_reg, 30'b0};

    gdh_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .val   (sq_val),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_CC:
            begin
                mul_a = 33'(c1_reg);
                mul_b = 33'(c2_reg);
            end
            S_MUL_A:
            begin
                mul_a = prod_reg[62:30];
                mul_b = {2'b0, hdn_reg};
            end
            S_MUL_T:
            begin
                mul_a = {9'b0, radius_reg};
                mul_b = {1'b0, half_reg, 1'b0};
            end
            S_MUL_LO:
            begin
                mul_a = {1'b0, prod_reg[31:0]};
                mul_b = {1'b0, gdh_pkg::TWO_PI_Q29};
            end
            S_MUL_HI:
            begin
                mul_a = {9'b0, th_reg};
                mul_b = {1'b0, gdh_pkg::TWO_PI_Q29};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign hav_full = 33'(gdh_pkg::ONE_Q30) - 33'(c_cos);
    assign a_sum    = $signed({3'b0, hdl_reg}) + prod_reg[63:30];
    assign mid      = 58'(prod_reg[56:0]) + 58'(mlo_reg) + 58'(1 << 20);
    assign d_full   = mid[57:21];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && func == gdh_pkg::FUNC_GOAL)
                    state_next = S_CSTART;
            S_CSTART:   state_next = S_CWAIT;
            S_CWAIT:
                if (c_done)
                begin
                    if (op_reg == OP_BEARING)
                        state_next = S_MUL_CC;
                    else if (op_reg == OP_HALF)
                        state_next = S_MUL_T;
                    else
                        state_next = S_CSTART;
                end
            S_MUL_CC:   state_next = S_MUL_A;
            S_MUL_A:    state_next = S_SUM_A;
            S_SUM_A:    state_next = S_SQS_GO;
            S_SQS_GO:   state_next = S_SQS_WAIT;
            S_SQS_WAIT:
                if (sq_done)
                    state_next = S_SQK_GO;
            S_SQK_GO:   state_next = S_SQK_WAIT;
            S_SQK_WAIT:
                if (sq_done)
                    state_next = S_CSTART;
            S_MUL_T:    state_next = S_MUL_LO;
            S_MUL_LO:   state_next = S_MUL_HI;
            S_MUL_HI:   state_next = S_FINAL;
            S_FINAL:    state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_COS_LAT1;
            radius_reg    <= gdh_pkg::RADIUS_RESET;
            cur_lat_reg   <= '0;
            cur_lon_reg   <= '0;
            cur_hdg_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
                radius_reg <= cfg_write_data;
            if (accept)
            begin
                case (func)
                    gdh_pkg::FUNC_POS:
                    begin
                        cur_lat_reg <= latitude;
                        cur_lon_reg <= longitude;
                    end
                    gdh_pkg::FUNC_HDG:  cur_hdg_reg <= heading;
                    gdh_pkg::FUNC_GOAL: op_reg <= OP_COS_LAT1;
                    default:            ;
                endcase
            end
            if (state_reg == S_CWAIT && c_done)
            begin
                case (op_reg)
                    OP_COS_LAT1: op_reg <= OP_COS_LAT2;
                    OP_COS_LAT2: op_reg <= OP_COS_DLAT;
                    OP_COS_DLAT: op_reg <= OP_COS_DLON;
                    OP_COS_DLON: op_reg <= OP_BEARING;
                    default:     op_reg <= op_reg;
                endcase
            end
            if (state_reg == S_SQK_WAIT && sq_done)
                op_reg <= OP_HALF;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept && func == gdh_pkg::FUNC_GOAL)
        begin
            lat2_reg <= latitude;
            dlat_reg <= latitude - cur_lat_reg;
            dlon_reg <= longitude - cur_lon_reg;
        end
        if (state_reg == S_CWAIT && c_done)
        begin
            case (op_reg)
                OP_COS_LAT1: c1_reg <= c_cos;
                OP_COS_LAT2: c2_reg <= c_cos;
                OP_COS_DLAT: hdl_reg <= hav_full[31:1];
                OP_COS_DLON: hdn_reg <= hav_full[31:1];
                OP_BEARING:  bearing_reg <= c_ang;
                default:     half_reg <= (c_ang > 32'(gdh_pkg::ONE_Q30))
                                         ? gdh_pkg::ONE_Q30 : c_ang[30:0];
            endcase
        end
        if (state_reg == S_SUM_A)
        begin
            if (a_sum[33])
                a_reg <= '0;
            else if (a_sum > 34'(gdh_pkg::ONE_Q30))
                a_reg <= gdh_pkg::ONE_Q30;
            else
                a_reg <= a_sum[30:0];
        end
        if (state_reg == S_SQS_WAIT && sq_done)
            s_reg <= sq_root;
        if (state_reg == S_SQK_WAIT && sq_done)
            k_reg <= sq_root;
        if (state_reg == S_MUL_LO)
            th_reg <= prod_reg[55:32];
        if (state_reg == S_MUL_HI)
            mlo_reg <= prod_reg[63:32];
        if (state_reg == S_FINAL)
            dist_reg <= (d_full > 37'(gdh_pkg::DIST_MAX)) ? gdh_pkg::DIST_MAX : d_full[32:0];
        if (state_reg == S_DONE && out_free)
        begin
            out_dist_reg <= dist_reg;
            out_herr_reg <= bearing_reg - cur_hdg_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign distance      = out_dist_reg;
    assign heading_error = out_herr_reg;

endmodule

// ----- rtl/gdh_cordic.sv -----
// Iterative CORDIC unit, one micro-rotation per cycle, rotation (cosine) or vectoring (atan2).
module gdh_cordic #(
    parameter int CORDIC_STAGES = gdh_pkg::CORDIC_STAGES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gdh_pkg::cordic_req_t req,
    output logic                 done,
    output logic signed [31:0]   cos_val,
    output logic [31:0]          angle
);

    localparam int IW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int CW = gdh_pkg::CW;
    localparam int ZW = gdh_pkg::ZW;
    localparam logic signed [CW-1:0] ONE_C = CW'(gdh_pkg::ONE_Q30);

    logic                 busy_reg;
    logic                 done_reg;
    logic [IW-1:0]        i_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic                 vec_reg;
    logic                 neg_reg;
    logic                 zero_reg;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] t;
    logic                 pos;
    logic [31:0]          ang_f;
    logic                 fold;
    logic signed [CW-1:0] xs_in;
    logic signed [CW-1:0] ys_in;
    logic signed [CW-1:0] xn;

    assign dx  = y_reg >>> i_reg;
    assign dy  = x_reg >>> i_reg;
    assign t   = ZW'(gdh_pkg::atan_entry(6'(i_reg)));
    assign pos = vec_reg ? y_reg[CW-1] : !z_reg[ZW-1];

    assign fold  = (req.ang[31:30] == 2'b01) || (req.ang[31:30] == 2'b10);
    assign ang_f = fold ? {~req.ang[31], req.ang[30:0]} : req.ang;
    assign xs_in = {{(CW-48){req.x[31]}}, req.x, 16'b0};
    assign ys_in = {{(CW-48){req.y[31]}}, req.y, 16'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (i_reg == IW'(CORDIC_STAGES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            vec_reg <= req.vec;
            if (req.vec)
            begin
                neg_reg  <= 1'b0;
                zero_reg <= (req.x == 32'sd0) && (req.y == 32'sd0);
                if (req.x[31])
                begin
                    x_reg <= -xs_in;
                    y_reg <= -ys_in;
                    z_reg <= ZW'(34'sh0_8000_0000);
                end
                else
                begin
                    x_reg <= xs_in;
                    y_reg <= ys_in;
                    z_reg <= '0;
                end
            end
            else
            begin
                neg_reg  <= fold;
                zero_reg <= 1'b0;
                x_reg    <= CW'(gdh_pkg::CORDIC_GAIN_Q30);
                y_reg    <= '0;
                z_reg    <= {{(ZW-32){ang_f[31]}}, ang_f};
            end
        end
        else if (busy_reg)
        begin
            if (pos)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - t;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + t;
            end
        end
    end

    assign xn = neg_reg ? -x_reg : x_reg;

    always_comb
    begin
        if (xn > ONE_C)
            cos_val = 32'sh4000_0000;
        else if (xn < -ONE_C)
            cos_val = -32'sh4000_0000;
        else
            cos_val = xn[31:0];
    end

    assign angle = zero_reg ? 32'd0 : z_reg[31:0];
    assign done  = done_reg;

endmodule

// ----- rtl/gdh_isqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
module gdh_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [60:0] val,
    output logic        done,
    output logic [31:0] root
);

    localparam int W = gdh_pkg::SQ_W;

    logic         busy_reg;
    logic         done_reg;
    logic [W-1:0] v_reg;
    logic [W-1:0] res_reg;
    logic [W-1:0] bit_reg;
    logic [W-1:0] sum;

    assign sum = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= W'(val);
            res_reg <= '0;
            bit_reg <= W'(1) << (W - 2);
        end
        else if (busy_reg)
        begin
            if (v_reg >= sum)
            begin
                v_reg   <= v_reg - sum;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ----- dv/gps_distance_heading_error_tb.sv -----
// Testbench for the great-circle distance and heading error block.
`timescale 1ns / 1ps

typedef struct {
    bit [32:0] span;
    bit [31:0] herr;
} nav_result_t;

class nav_board;
    localparam int STAGES = 32;
    localparam longint ONE = 64'd1073741824;
    localparam longint GAIN = 64'd652032874;
    localparam bit [63:0] TWO_PI = 64'd3373259426;
    localparam bit [63:0] DMAX = 64'h1_FFFF_FFFF;

    longint arc_tab[STAGES] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1, 1, 0};

    bit [23:0] radius;
    bit [31:0] fix_lat;
    bit [31:0] fix_lon;
    bit [31:0] compass;
    nav_result_t awaiting[$];
    int errors;
    int checked;

    function new();
        radius = gdh_pkg::RADIUS_RESET;
        fix_lat = 0;
        fix_lon = 0;
        compass = 0;
        errors = 0;
        checked = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint cos_q30(bit [31:0] ang);
        bit flip;
        longint x, y, z, dx, dy;
        flip = 0;
        x = GAIN;
        y = 0;
        if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2)
        begin
            ang = ang + 32'h8000_0000;
            flip = 1;
        end
        z = longint'($signed(ang));
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arc_tab[i];
            end
            else
            begin
                x += dx; y -= dy; z += arc_tab[i];
            end
        end
        if (flip)
            x = -x;
        return clip(x, -ONE, ONE);
    endfunction

    function bit [31:0] arc_tan2(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0)
        begin
            x = -x; y = -y; z = 64'd2147483648;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += arc_tab[i];
            end
            else
            begin
                x -= dx; y += dy; z -= arc_tab[i];
            end
        end
        return z[31:0];
    endfunction

    function bit [63:0] root(bit [63:0] v);
        bit [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function longint hav(bit [31:0] ang);
        return clip((ONE - cos_q30(ang)) >>> 1, 0, ONE);
    endfunction

    function bit [32:0] great_circle(bit [31:0] lat2, bit [31:0] lon2);
        longint cc, a, half;
        bit [63:0] s, k, t, th, tl, mid, d;
        cc = (cos_q30(fix_lat) * cos_q30(lat2)) >>> 30;
        a = hav(lat2 - fix_lat) + ((cc * hav(lon2 - fix_lon)) >>> 30);
        a = clip(a, 0, ONE);
        s = root(64'(a) << 30);
        k = root(64'(ONE - a) << 30);
        half = clip(longint'({32'd0, arc_tan2(longint'(s), longint'(k))}), 0, ONE);
        t = 64'(radius) * 64'(half * 2);
        th = t >> 32;
        tl = t & 64'hFFFF_FFFF;
        mid = th * TWO_PI + ((tl * TWO_PI) >> 32);
        d = (mid + (64'd1 << 20)) >> 21;
        return d > DMAX ? DMAX[32:0] : d[32:0];
    endfunction

    function void note_word(bit [1:0] f, bit [31:0] lat, bit [31:0] lon, bit [31:0] hdg);
        nav_result_t r;
        bit [31:0] bearing;
        if (f == gdh_pkg::FUNC_POS)
        begin
            fix_lat = lat;
            fix_lon = lon;
        end
        else if (f == gdh_pkg::FUNC_HDG)
            compass = hdg;
        else if (f == gdh_pkg::FUNC_GOAL)
        begin
            bearing = arc_tan2(longint'($signed(lon - fix_lon)),
                               longint'($signed(lat - fix_lat)));
            r.span = great_circle(lat, lon);
            r.herr = bearing - compass;
            awaiting.push_back(r);
        end
    endfunction

    function void check_word(bit [32:0] span, bit [31:0] herr);
        nav_result_t e;
        if (awaiting.size() == 0)
        begin
            $display("%0t unexpected result distance %0d heading_error %0d",
                     $time, span, $signed(herr));
            errors++;
            return;
        end
        e = awaiting.pop_front();
        checked++;
        if (span !== e.span)
        begin
            $display("%0t distance exp %0d got %0d", $time, e.span, span);
            errors++;
        end
        if (herr !== e.herr)
        begin
            $display("%0t heading_error exp %0d got %0d", $time,
                     $signed(e.herr), $signed(herr));
            errors++;
        end
    endfunction
endclass

module gps_distance_heading_error_tb;
    localparam int SETTLE = 400;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [23:0] cfg_write_data;
    logic in_valid;
    logic in_stall;
    logic [1:0] func;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] heading;
    logic out_valid;
    logic out_stall;
    logic [32:0] distance;
    logic signed [31:0] heading_error;

    nav_board board;
    int idle_mode;
    bit hold_req;
    int hold_cnt;
    int sent;
    int radii;

    gps_distance_heading_error u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .latitude(latitude),
        .longitude(longitude),
        .heading(heading),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .distance(distance),
        .heading_error(heading_error)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_word(func, latitude, longitude, heading);
        if (rst_n && out_valid && !out_stall)
            board.check_word(distance, heading_error);
    end

    initial
    begin
        out_stall = 0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1;
                hold_cnt++;
                if (hold_cnt == 3000)
                begin
                    hold_req = 0;
                    hold_cnt = 0;
                end
            end
            else if (idle_mode == 2)
                out_stall <= $urandom_range(99) < 81;
            else if (idle_mode == 3)
                out_stall <= $urandom_range(99) < 8;
            else
                out_stall <= 0;
        end
    end

    initial
    begin
        #30ms;
        $display("status: fail");
        $finish;
    end

    task automatic send_word(bit [1:0] f, bit [31:0] lat, bit [31:0] lon, bit [31:0] hdg);
        in_valid <= 1;
        func <= f;
        latitude <= lat;
        longitude <= lon;
        heading <= hdg;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        sent++;
        if ((idle_mode == 1 && $urandom_range(99) < 81) ||
            (idle_mode == 3 && $urandom_range(99) < 8))
        begin
            in_valid <= 0;
            @(posedge clk);
            while ((idle_mode == 1 && $urandom_range(99) < 81) ||
                   (idle_mode == 3 && $urandom_range(99) < 8))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (board.awaiting.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_radius(bit [23:0] r);
        drain();
        cfg_write_en <= 1;
        cfg_write_data <= r;
        @(posedge clk);
        cfg_write_en <= 0;
        board.radius = r;
        radii++;
    endtask

    function automatic bit [31:0] rand_lat();
        case ($urandom_range(9))
            0: return 32'h4000_0000;
            1: return 32'hC000_0000;
            2: return $urandom;
            default: return $urandom_range(32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    task automatic random_words(int n);
        bit [31:0] lat, lon;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4: send_word(gdh_pkg::FUNC_POS, rand_lat(), $urandom, $urandom);
                5, 6, 7: send_word(gdh_pkg::FUNC_HDG, $urandom, $urandom, $urandom);
                8: send_word(2'd3, $urandom, $urandom, $urandom);
                9, 10, 11:
                begin
                    lat = board.fix_lat + $urandom_range(2000) - 1000;
                    lon = board.fix_lon + $urandom_range(2000) - 1000;
                    send_word(gdh_pkg::FUNC_GOAL, lat, lon, $urandom);
                end
                default: send_word(gdh_pkg::FUNC_GOAL, rand_lat(), $urandom, $urandom);
            endcase
        end
    endtask

    initial
    begin
        board = new();
        idle_mode = 0;
        hold_req = 0;
        sent = 0;
        radii = 0;
        rst_n = 0;
        cfg_write_en = 0;
        cfg_write_data = 0;
        in_valid = 0;
        func = 0;
        latitude = 0;
        longitude = 0;
        heading = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_word(gdh_pkg::FUNC_GOAL, 0, 0, 0);
        send_word(gdh_pkg::FUNC_GOAL, 32'h4000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(gdh_pkg::FUNC_GOAL, 32'hC000_0000, 32'h8000_0000, 0);
        send_word(gdh_pkg::FUNC_HDG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_word(gdh_pkg::FUNC_GOAL, 0, 32'h8000_0000, 0);
        send_word(gdh_pkg::FUNC_HDG, 0, 0, 32'h7FFF_FFFF);
        send_word(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(gdh_pkg::FUNC_GOAL, 32'h1000_0000, 32'h2000_0000, 0);
        send_word(gdh_pkg::FUNC_POS, 32'h4000_0000, 32'h8000_0000, 0);
        send_word(gdh_pkg::FUNC_GOAL, 32'hC000_0000, 32'h7FFF_FFFF, 0);
        send_word(gdh_pkg::FUNC_GOAL, 32'h4000_0000, 32'h8000_0000, 0);
        send_word(gdh_pkg::FUNC_POS, 32'h7FFF_FFFF, 32'h0, 0);
        send_word(gdh_pkg::FUNC_GOAL, 32'h8000_0000, 32'h1, 0);
        send_word(gdh_pkg::FUNC_GOAL, 32'h6000_0000, 32'hFFFF_FFFF, 0);
        send_word(gdh_pkg::FUNC_POS, 32'h1234_5678, 32'h9ABC_DEF0, 0);
        send_word(gdh_pkg::FUNC_GOAL, 32'h1234_5679, 32'h9ABC_DEEF, 0);

        set_radius(24'hFF_FFFF);
        send_word(gdh_pkg::FUNC_GOAL, 32'hC000_0000, 32'h4000_0000, 0);
        set_radius(0);
        send_word(gdh_pkg::FUNC_GOAL, 32'h2000_0000, 32'h3000_0000, 0);
        set_radius(1);
        send_word(gdh_pkg::FUNC_GOAL, 32'hC000_0000, 32'h4000_0000, 0);
        set_radius(gdh_pkg::RADIUS_RESET);

        for (int ph = 0; ph < 8; ph++)
        begin
            idle_mode = ph % 4;
            if (ph == 5)
            begin
                set_radius($urandom_range(24'hFF_FFFF, 1));
                hold_req = 1;
            end
            if (ph == 6)
                set_radius(24'hFF_FFFF);
            if (ph == 7)
                set_radius(1);
            random_words(48);
            if (ph == 3)
                drain();
        end

        idle_mode = 0;
        drain();
        $display("sent %0d words, checked %0d goal results over %0d radius settings",
                 sent, board.checked, radii);
        $display("idle, stall, long hold-off and drain phases were exercised");
        if (board.errors == 0 && board.awaiting.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- gps_distance_heading_error.f -----
rtl/gdh_pkg.sv
rtl/gdh_cordic.sv
rtl/gdh_isqrt.sv
rtl/gps_distance_heading_error.sv
dv/gps_distance_heading_error_tb.sv
